>>> hdl/akt_pkg.sv
// Shared types and constants for the aging key table.
`default_nettype none

package akt_pkg;

    // Default table depth
    localparam int unsigned CAPACITY_DEF = 8;

    // Field widths
    localparam int unsigned KEY_W   = 16;
    localparam int unsigned COMP_W  = 16;
    localparam int unsigned TIMER_W = 16;
    localparam int unsigned FUNC_W  = 3;
    localparam int unsigned COUNT_OUT_W = 4;

    // Operation codes; the two highest codes are no-ops
    typedef enum logic [FUNC_W-1:0] {
        FUNC_APPEND = 3'd0,
        FUNC_REMOVE = 3'd1,
        FUNC_QUERY  = 3'd2,
        FUNC_TICK   = 3'd3,
        FUNC_PURGE  = 3'd4,
        FUNC_CLEAR  = 3'd5
    } t_func;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } t_state;

    // One table entry as stored in the memory
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COMP_W-1:0]  comp;
        logic [TIMER_W-1:0] timer;
    } t_entry;

endpackage

`default_nettype wire

>>> hdl/akt_mem.sv
// Entry memory: one write port, one read port with registered read data.
`default_nettype none

module akt_mem
    import akt_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_DEF,
    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_entry        i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output t_entry             o_rdata
);

    t_entry r_mem [CAPACITY];
    t_entry r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hdl/akt_ctrl.sv
// Sequencer: decodes a transaction, walks the entry memory and holds the result.
`default_nettype none

module akt_ctrl
    import akt_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_DEF,
    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // input channel
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [FUNC_W-1:0]      i_func,
    input  wire logic [KEY_W-1:0]       i_key_id,
    input  wire logic [COMP_W-1:0]      i_companion_id,
    input  wire logic [TIMER_W-1:0]     i_start_ticks,
    // output channel
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic                        o_hit,
    output logic                        o_dropped,
    output logic [COUNT_OUT_W-1:0]      o_entry_count,
    // memory side
    output logic                        o_mem_we,
    output logic [AW-1:0]               o_mem_waddr,
    output t_entry                      o_mem_wdata,
    output logic [AW-1:0]               o_mem_raddr,
    input  wire t_entry                 i_mem_rdata
);

    t_state                   r_state, n_state;
    t_func                    r_func, n_func;
    logic [KEY_W-1:0]         r_key, n_key;
    logic [CW-1:0]            r_count, n_count;
    logic [CW-1:0]            r_rd_idx, n_rd_idx;
    logic [CW-1:0]            r_wr_idx, n_wr_idx;
    logic                     r_pend, n_pend;
    logic                     r_found, n_found;
    logic                     r_res_hit, n_res_hit;
    logic                     r_res_drop, n_res_drop;
    logic                     r_out_valid, n_out_valid;
    logic                     r_out_hit, n_out_hit;
    logic                     r_out_drop, n_out_drop;
    logic [COUNT_OUT_W-1:0]   r_out_count, n_out_count;

    logic                     issue;
    logic                     keep;
    logic                     match;
    t_entry                   upd;
    t_func                    in_func;

    assign in_func = t_func'(i_func);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_key       <= n_key;
        r_rd_idx    <= n_rd_idx;
        r_wr_idx    <= n_wr_idx;
        r_found     <= n_found;
        r_res_hit   <= n_res_hit;
        r_res_drop  <= n_res_drop;
        r_out_hit   <= n_out_hit;
        r_out_drop  <= n_out_drop;
        r_out_count <= n_out_count;
    end

    // Next state, walk datapath and memory control
    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_key       = r_key;
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        n_wr_idx    = r_wr_idx;
        n_pend      = r_pend;
        n_found     = r_found;
        n_res_hit   = r_res_hit;
        n_res_drop  = r_res_drop;
        n_out_hit   = r_out_hit;
        n_out_drop  = r_out_drop;
        n_out_count = r_out_count;
        // output register empties when taken
        n_out_valid = r_out_valid && i_out_stall;

        o_mem_we    = 1'b0;
        o_mem_waddr = r_wr_idx[AW-1:0];
        o_mem_raddr = r_rd_idx[AW-1:0];
        upd         = i_mem_rdata;
        o_mem_wdata = i_mem_rdata;

        issue = r_rd_idx < r_count;
        match = i_mem_rdata.key == r_key;
        keep  = 1'b1;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_func     = in_func;
                    n_key      = i_key_id;
                    n_found    = 1'b0;
                    n_res_hit  = 1'b0;
                    n_res_drop = 1'b0;
                    n_rd_idx   = '0;
                    n_wr_idx   = '0;
                    n_pend     = 1'b0;
                    unique case (in_func) inside
                        FUNC_APPEND: begin
                            if (r_count >= CW'(CAPACITY)) begin
                                n_res_drop = 1'b1;
                            end else begin
                                o_mem_we         = 1'b1;
                                o_mem_waddr      = r_count[AW-1:0];
                                o_mem_wdata.key  = i_key_id;
                                o_mem_wdata.comp = i_companion_id;
                                o_mem_wdata.timer = i_start_ticks;
                                n_count          = r_count + CW'(1);
                            end
                            n_state = ST_DONE;
                        end
                        FUNC_CLEAR: begin
                            n_count = '0;
                            n_state = ST_DONE;
                        end
                        FUNC_REMOVE, FUNC_QUERY, FUNC_TICK, FUNC_PURGE: begin
                            n_state = ST_WALK;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end

            ST_WALK: begin
                // issue the next read
                n_pend = issue;
                if (issue) begin
                    n_rd_idx = r_rd_idx + CW'(1);
                end
                // process the entry read last cycle
                if (r_pend) begin
                    case (r_func)
                        FUNC_REMOVE: begin
                            if (!r_found && match) begin
                                n_found = 1'b1;
                                keep    = 1'b0;
                            end
                        end
                        FUNC_QUERY: begin
                            if (match) begin
                                n_found = 1'b1;
                            end
                            keep = 1'b0;
                        end
                        FUNC_TICK: begin
                            if (i_mem_rdata.timer != '0) begin
                                upd.timer = i_mem_rdata.timer - TIMER_W'(1);
                            end
                        end
                        FUNC_PURGE: begin
                            keep = i_mem_rdata.timer != '0;
                        end
                        default: begin
                            keep = 1'b0;
                        end
                    endcase
                    o_mem_wdata = upd;
                    if (keep) begin
                        o_mem_we = 1'b1;
                        n_wr_idx = r_wr_idx + CW'(1);
                    end
                end
                // walk complete
                if (!issue && !r_pend) begin
                    if (r_func == FUNC_REMOVE || r_func == FUNC_PURGE) begin
                        n_count = r_wr_idx;
                    end
                    n_res_hit = r_found;
                    n_state   = ST_DONE;
                end
            end

            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_hit   = r_res_hit;
                    n_out_drop  = r_res_drop;
                    n_out_count = COUNT_OUT_W'(r_count);
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall    = r_state != ST_IDLE;
    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_out_hit;
    assign o_dropped     = r_out_drop;
    assign o_entry_count = r_out_count;

endmodule

`default_nettype wire

>>> hdl/aging_key_table.sv
// Top level of the aging key table: sequencer plus entry memory.
`default_nettype none

// Ordered table of up to CAPACITY entries (key, companion, countdown timer)
// kept in one synchronous memory. Append, clear and the unused codes pass
// from acceptance straight to the done state and then to the output
// register; remove, query, tick and purge first walk every live entry
// through the single memory read port, one entry per cycle. Remove and
// purge compact the table in the same pass by writing kept entries back at
// a trailing write pointer. One transaction is processed at a time; the
// next is accepted on the cycle after the result is registered, and the
// result can wait in the done state for a stalled output register. The
// memory needs no clearing after reset: only entries below the live count
// are ever processed.
module aging_key_table
    import akt_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [FUNC_W-1:0]      i_func,
    input  wire logic [KEY_W-1:0]       i_key_id,
    input  wire logic [COMP_W-1:0]      i_companion_id,
    input  wire logic [TIMER_W-1:0]     i_start_ticks,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic                        o_hit,
    output logic                        o_dropped,
    output logic [COUNT_OUT_W-1:0]      o_entry_count
);

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    t_entry        mem_wdata;
    t_entry        mem_rdata;

    // Sequencer
    akt_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_key_id       (i_key_id),
        .i_companion_id (i_companion_id),
        .i_start_ticks  (i_start_ticks),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_hit          (o_hit),
        .o_dropped      (o_dropped),
        .o_entry_count  (o_entry_count),
        .o_mem_we       (mem_we),
        .o_mem_waddr    (mem_waddr),
        .o_mem_wdata    (mem_wdata),
        .o_mem_raddr    (mem_raddr),
        .i_mem_rdata    (mem_rdata)
    );

    // Entry storage
    akt_mem #(
        .CAPACITY(CAPACITY)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

`default_nettype wire

>>> bench/testbench.sv
// Self-checking testbench for the aging key table.
`default_nettype none

module testbench;
    import akt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Spare opcodes; the block treats them as no-ops
    localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

    localparam bit TYPED     = 1'b1;
    localparam bit PREDICTED = 1'b0;

    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 150;
    localparam int HOLD_CYCLES  = 120;
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 20;
    localparam int N_DIRECTED   = 27;

    typedef struct packed {
        logic                   hit;
        logic                   dropped;
        logic [COUNT_OUT_W-1:0] count;
    } t_table_result;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [KEY_W-1:0]   key;
        logic [COMP_W-1:0]  comp;
        logic [TIMER_W-1:0] ticks;
        logic               typed;
        t_table_result      res;
    } t_directed_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic [FUNC_W-1:0]      i_func;
    logic [KEY_W-1:0]       i_key_id;
    logic [COMP_W-1:0]      i_companion_id;
    logic [TIMER_W-1:0]     i_start_ticks;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic                   o_hit;
    logic                   o_dropped;
    logic [COUNT_OUT_W-1:0] o_entry_count;

    aging_key_table dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_key_id       (i_key_id),
        .i_companion_id (i_companion_id),
        .i_start_ticks  (i_start_ticks),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_hit          (o_hit),
        .o_dropped      (o_dropped),
        .o_entry_count  (o_entry_count)
    );

    // Shadow copy of the table
    logic [KEY_W-1:0]   key_tab   [CAPACITY_DEF];
    logic [COMP_W-1:0]  comp_tab  [CAPACITY_DEF];
    logic [TIMER_W-1:0] timer_tab [CAPACITY_DEF];
    int                 live_entries = 0;

    t_table_result pending_results [$];
    int            error_count  = 0;
    int            quiet_cycles = 0;

    // Sender/receiver coordination
    bit            idle_on  = 1'b1;
    bit            hold_req = 1'b0;
    bit            row_typed = 1'b0;
    t_table_result row_result = '0;

    logic [KEY_W-1:0] key_pool [6];

    // Directed rows: typed results where obvious, predictor elsewhere
    t_directed_row directed_rows [N_DIRECTED] = '{
        '{FUNC_QUERY,  16'h0000, 16'h0000, 16'h0000, TYPED, '{1'b0, 1'b0, 4'd0}},
        '{FUNC_REMOVE, 16'hFFFF, 16'h0000, 16'h0000, TYPED, '{1'b0, 1'b0, 4'd0}},
        '{FUNC_TICK,   16'h0000, 16'h0000, 16'h0000, TYPED, '{1'b0, 1'b0, 4'd0}},
        '{FUNC_PURGE,  16'h0000, 16'h0000, 16'h0000, TYPED, '{1'b0, 1'b0, 4'd0}},
        '{FUNC_APPEND, 16'h0000, 16'h0000, 16'h0000, TYPED, '{1'b0, 1'b0, 4'd1}},
        '{FUNC_APPEND, 16'hFFFF, 16'hFFFF, 16'hFFFF, TYPED, '{1'b0, 1'b0, 4'd2}},
        '{FUNC_APPEND, 16'h1234, 16'hABCD, 16'h0001, TYPED, '{1'b0, 1'b0, 4'd3}},
        '{FUNC_APPEND, 16'h1234, 16'h5555, 16'h0002, TYPED, '{1'b0, 1'b0, 4'd4}},
        '{FUNC_APPEND, 16'h00FF, 16'hFF00, 16'h0003, TYPED, '{1'b0, 1'b0, 4'd5}},
        '{FUNC_APPEND, 16'h8000, 16'h0001, 16'h0000, TYPED, '{1'b0, 1'b0, 4'd6}},
        '{FUNC_APPEND, 16'h7FFF, 16'h8000, 16'h0001, TYPED, '{1'b0, 1'b0, 4'd7}},
        '{FUNC_APPEND, 16'hAAAA, 16'h5555, 16'h0005, TYPED, '{1'b0, 1'b0, 4'd8}},
        '{FUNC_APPEND, 16'h5555, 16'hAAAA, 16'h0007, TYPED, '{1'b0, 1'b1, 4'd8}},
        '{FUNC_QUERY,  16'h1234, 16'h0000, 16'h0000, TYPED, '{1'b1, 1'b0, 4'd8}},
        '{FUNC_QUERY,  16'h4321, 16'h0000, 16'h0000, TYPED, '{1'b0, 1'b0, 4'd8}},
        '{FUNC_REMOVE, 16'h4321, 16'h0000, 16'h0000, TYPED, '{1'b0, 1'b0, 4'd8}},
        '{FUNC_REMOVE, 16'h1234, 16'h0000, 16'h0000, TYPED, '{1'b1, 1'b0, 4'd7}},
        '{FUNC_QUERY,  16'h1234, 16'h0000, 16'h0000, PREDICTED, '0},
        '{FUNC_SPARE_LO, 16'hFFFF, 16'hFFFF, 16'hFFFF, TYPED, '{1'b0, 1'b0, 4'd7}},
        '{FUNC_SPARE_HI, 16'h0000, 16'h0000, 16'h0000, TYPED, '{1'b0, 1'b0, 4'd7}},
        '{FUNC_TICK,   16'h0000, 16'h0000, 16'h0000, TYPED, '{1'b0, 1'b0, 4'd7}},
        '{FUNC_PURGE,  16'h0000, 16'h0000, 16'h0000, PREDICTED, '0},
        '{FUNC_TICK,   16'h0000, 16'h0000, 16'h0000, PREDICTED, '0},
        '{FUNC_PURGE,  16'h0000, 16'h0000, 16'h0000, PREDICTED, '0},
        '{FUNC_CLEAR,  16'h0000, 16'h0000, 16'h0000, TYPED, '{1'b0, 1'b0, 4'd0}},
        '{FUNC_QUERY,  16'h0000, 16'h0000, 16'h0000, TYPED, '{1'b0, 1'b0, 4'd0}},
        '{FUNC_APPEND, 16'h0001, 16'h0002, 16'h0003, TYPED, '{1'b0, 1'b0, 4'd1}}
    };

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic flag_error(input string what);
        $display("ERROR at %0t: %s", $time, what);
        error_count++;
    endtask

    // Applies one transaction to the shadow table and returns its result
    task automatic apply_to_table(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
                                  input logic [COMP_W-1:0] c, input logic [TIMER_W-1:0] t,
                                  output t_table_result r);
        int pos;
        int w;
        r = '0;
        pos = -1;
        w = 0;
        case (f)
            FUNC_APPEND: begin
                if (live_entries >= int'(CAPACITY_DEF)) begin
                    r.dropped = 1'b1;
                end else begin
                    key_tab[live_entries]   = k;
                    comp_tab[live_entries]  = c;
                    timer_tab[live_entries] = t;
                    live_entries++;
                end
            end
            FUNC_REMOVE, FUNC_QUERY: begin
                for (int i = 0; i < live_entries; i++)
                    if (pos < 0 && key_tab[i] == k) pos = i;
                if (pos >= 0) begin
                    r.hit = 1'b1;
                    // first match only; later entries shift down in order
                    if (f == FUNC_REMOVE) begin
                        for (int i = pos; i < live_entries - 1; i++) begin
                            key_tab[i]   = key_tab[i+1];
                            comp_tab[i]  = comp_tab[i+1];
                            timer_tab[i] = timer_tab[i+1];
                        end
                        live_entries--;
                    end
                end
            end
            FUNC_TICK: begin
                // timers stop at zero
                for (int i = 0; i < live_entries; i++)
                    if (timer_tab[i] != '0) timer_tab[i] = timer_tab[i] - 1'b1;
            end
            FUNC_PURGE: begin
                for (int i = 0; i < live_entries; i++) begin
                    if (timer_tab[i] != '0) begin
                        key_tab[w]   = key_tab[i];
                        comp_tab[w]  = comp_tab[i];
                        timer_tab[w] = timer_tab[i];
                        w++;
                    end
                end
                live_entries = w;
            end
            FUNC_CLEAR: live_entries = 0;
            default: ;
        endcase
        r.count = COUNT_OUT_W'(live_entries);
    endtask

    // Monitor: predicts on input transactions, checks output transactions
    always @(posedge i_clk) begin
        t_table_result predicted;
        t_table_result wanted;
        quiet_cycles++;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                quiet_cycles = 0;
                apply_to_table(i_func, i_key_id, i_companion_id, i_start_ticks, predicted);
                pending_results.push_back(row_typed ? row_result : predicted);
            end
            if (o_out_valid && !i_out_stall) begin
                quiet_cycles = 0;
                if (pending_results.size() == 0) begin
                    flag_error("result with no transaction pending");
                end else begin
                    wanted = pending_results.pop_front();
                    if (o_hit !== wanted.hit)
                        flag_error($sformatf("hit got %b want %b", o_hit, wanted.hit));
                    if (o_dropped !== wanted.dropped)
                        flag_error($sformatf("dropped got %b want %b",
                                             o_dropped, wanted.dropped));
                    if (o_entry_count !== wanted.count)
                        flag_error($sformatf("entry_count got %0d want %0d",
                                             o_entry_count, wanted.count));
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either side
    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("ERROR at %0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // Output side: random stall bursts, one long hold on request
    initial begin
        i_out_stall = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(0, 14)) @(negedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat (idle_on ? $urandom_range(0, 19) : 0) @(negedge i_clk);
            end
        end
    end

    // Offers one transaction, after an optional idle burst, and waits for it to go in
    task automatic send_item(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
                             input logic [COMP_W-1:0] c, input logic [TIMER_W-1:0] t,
                             input bit typed, input t_table_result typed_res);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 15);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_func         <= f;
        i_key_id       <= k;
        i_companion_id <= c;
        i_start_ticks  <= t;
        row_typed  = typed;
        row_result = typed_res;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Sender goes quiet until every result is back
    task automatic drain;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Random transaction, mostly on a small key pool so hits and duplicates happen
    task automatic pick_item(output logic [FUNC_W-1:0] f, output logic [KEY_W-1:0] k,
                             output logic [COMP_W-1:0] c, output logic [TIMER_W-1:0] t);
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)      f = FUNC_APPEND;
        else if (r < 55) f = FUNC_REMOVE;
        else if (r < 69) f = FUNC_QUERY;
        else if (r < 83) f = FUNC_TICK;
        else if (r < 94) f = FUNC_PURGE;
        else if (r < 97) f = FUNC_CLEAR;
        else             f = $urandom_range(0, 1) ? FUNC_SPARE_HI : FUNC_SPARE_LO;

        k = ($urandom_range(0, 99) < 80) ? key_pool[$urandom_range(0, 5)]
                                          : KEY_W'($urandom);
        c = COMP_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 70)      t = TIMER_W'($urandom_range(0, 3));
        else if (r < 90) t = TIMER_W'($urandom_range(0, 20));
        else             t = TIMER_W'($urandom);
    endtask

    // Main sequence
    initial begin
        logic [FUNC_W-1:0]  f;
        logic [KEY_W-1:0]   k;
        logic [COMP_W-1:0]  c;
        logic [TIMER_W-1:0] t;

        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_func         = '0;
        i_key_id       = '0;
        i_companion_id = '0;
        i_start_ticks  = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (directed_rows[i])
            send_item(directed_rows[i].func, directed_rows[i].key, directed_rows[i].comp,
                      directed_rows[i].ticks, directed_rows[i].typed, directed_rows[i].res);
        drain();

        // random phases; long output hold in the second, no idling in the last
        for (int phase = 0; phase < PHASES; phase++) begin
            foreach (key_pool[j]) key_pool[j] = KEY_W'($urandom);
            if (phase == 1) hold_req = 1'b1;
            if (phase == PHASES - 1) idle_on = 1'b0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick_item(f, k, c, t);
                send_item(f, k, c, t, PREDICTED, '0);
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) flag_error("results still pending at end");

        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
